@@ design/nfi_pkg.sv @@
// ----------------------------------------------------------------------------
// nfi_pkg
// Shared types, codes and saturating arithmetic helpers for the Newton
// forward-difference interpolator.
// ----------------------------------------------------------------------------
package nfi_pkg;

    localparam int NFI_MAX_POINTS = 16;
    localparam int NUM_W  = 49;
    localparam int DEN_W  = 40;
    localparam int DIV_BITS = 50;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_COMPUTE = 2'd1,
        CMD_EVAL    = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FEW       = 3'd1,
        ST_FULL      = 3'd2,
        ST_ZERO_STEP = 3'd3,
        ST_NOT_READY = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_C_EMIT0, S_C_START, S_C_MULK, S_C_DIVGO, S_C_DIVW, S_C_EMIT,
        S_E_DIVGO, S_E_DIVW, S_E_MUL1, S_E_RND1, S_E_ACC, S_E_MUL2, S_E_RND2,
        S_E_RESTORE
    } t_state;

    typedef struct packed {
        logic        load_en;
        logic        copy_en;
        logic        diff_en;
        logic        cwr_en;
        logic        rot_en;
        logic [31:0] y_data;
        logic [31:0] c_data;
    } t_cell_ctl;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] mul_round(input logic signed [63:0] p);
        logic        neg;
        logic [63:0] m;
        logic [63:0] r;
        neg = p[63];
        m   = neg ? 64'(-p) : 64'(p);
        r   = (m + 64'd32768) >> 16;
        if (neg) begin
            if (r > 64'd2147483648) begin
                return 32'sh80000000;
            end
            return 32'(64'd0 - r);
        end
        if (r > 64'd2147483647) begin
            return 32'sh7fffffff;
        end
        return r[31:0];
    endfunction

endpackage

@@ design/nfi_cell.sv @@
// ----------------------------------------------------------------------------
// nfi_cell
// One slot of the sample chain: stored ordinate, working difference and
// coefficient, exchanged with the next slot.
// ----------------------------------------------------------------------------
module nfi_cell (
    input  logic                  i_clk,
    input  nfi_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_sel,
    input  logic signed [31:0]    i_d_next,
    input  logic signed [31:0]    i_c_next,
    output logic signed [31:0]    o_d,
    output logic signed [31:0]    o_c
);
    import nfi_pkg::*;

    logic signed [31:0] r_y;
    logic signed [31:0] r_d;
    logic signed [31:0] r_c;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_en && i_sel) begin
            r_y <= i_ctl.y_data;
        end
        if (i_ctl.copy_en) begin
            r_d <= r_y;
        end else if (i_ctl.diff_en) begin
            r_d <= sat34(34'(i_d_next) - 34'(r_d));
        end
        if (i_ctl.cwr_en && i_sel) begin
            r_c <= i_ctl.c_data;
        end else if (i_ctl.rot_en) begin
            r_c <= i_c_next;
        end
    end

    assign o_d = r_d;
    assign o_c = r_c;

endmodule

@@ design/nfi_div.sv @@
// ----------------------------------------------------------------------------
// nfi_div
// Shared radix-2 restoring divider, rounds to nearest (ties away from zero)
// and saturates the quotient to 32 bits.
// ----------------------------------------------------------------------------
module nfi_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [nfi_pkg::NUM_W-1:0] i_num,
    input  logic signed [nfi_pkg::DEN_W-1:0] i_den,
    output logic                          o_done,
    output logic signed [31:0]            o_quot
);
    import nfi_pkg::*;

    localparam int CW = $clog2(DIV_BITS + 1);

    logic                 r_run;
    logic                 r_fin;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic                 r_neg;
    logic [DEN_W-1:0]     r_ub;
    logic [DIV_BITS-1:0]  r_dvd;
    logic [DEN_W:0]       r_rem;
    logic signed [31:0]   r_quot;

    logic [NUM_W-1:0]     ua;
    logic [DEN_W-1:0]     ub;
    logic [DEN_W:0]       t;
    logic                 qbit;

    always_comb begin
        ua   = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        ub   = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
        t    = {r_rem[DEN_W-1:0], r_dvd[DIV_BITS-1]};
        qbit = (t >= {1'b0, r_ub});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(DIV_BITS);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_ub  <= ub;
            r_dvd <= DIV_BITS'(ua) + DIV_BITS'(ub >> 1);
            r_rem <= '0;
        end else if (r_run) begin
            r_rem <= qbit ? (t - {1'b0, r_ub}) : t;
            r_dvd <= {r_dvd[DIV_BITS-2:0], qbit};
        end
        if (r_fin) begin
            if (r_neg) begin
                r_quot <= (r_dvd > DIV_BITS'(64'd2147483648)) ? 32'sh80000000
                                                               : 32'(-r_dvd);
            end else begin
                r_quot <= (r_dvd > DIV_BITS'(64'd2147483647)) ? 32'sh7fffffff
                                                               : r_dvd[31:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ design/newton_forward_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// newton_forward_interpolator_core
// Newton forward-difference interpolator over equally spaced Q16.16 samples.
// ----------------------------------------------------------------------------
// Usage: drive i_command, i_x_value, i_y_value with start; a request is taken
// on a rising edge with start high and busy low. Results come out on the
// o_ ports for one cycle each, marked by o_strobe; o_last flags the final
// result of a request. The receiver cannot stall: results are never held.
// Load commands and rejected requests keep busy low, and their result is
// registered and appears the next cycle; an ignored command gives no result.
// Compute runs one difference step per coefficient across the cell chain,
// then i chained divisions (denominator setup plus the shared divider) for
// coefficient i. Evaluate takes one division, then multiply, round,
// accumulate, multiply and round for each term on the shared multiplier, then
// rotates the coefficient chain back home.
// Reset empties the point store and clears the coefficient-ready flag;
// stored samples and coefficients are undefined until written.
// ----------------------------------------------------------------------------
module newton_forward_interpolator_core #(
    parameter int MAX_POINTS = nfi_pkg::NFI_MAX_POINTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_command,
    input  logic signed [31:0] i_x_value,
    input  logic signed [31:0] i_y_value,
    output logic               o_strobe,
    output logic signed [31:0] o_result_value,
    output logic [3:0]         o_coef_index,
    output logic [2:0]         o_status,
    output logic               o_last
);
    import nfi_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    t_state r_state, n_state;

    logic [CNT_W-1:0]   r_count, r_i, r_k, r_rot;
    logic               r_ready;
    logic signed [31:0] r_origin, r_step;
    logic signed [31:0] r_acc, r_q, r_prod, r_res, r_t, r_qm;
    logic signed [63:0] r_p;
    logic signed [NUM_W-1:0] r_num;
    logic signed [DEN_W-1:0] r_den;

    logic               r_strobe, n_strobe;
    logic signed [31:0] r_result, n_result;
    logic [3:0]         r_index, n_index;
    t_status            r_status, n_status;
    logic               r_last, n_last;

    t_cell_ctl          ctl;
    logic               div_start, div_done;
    logic signed [31:0] div_quot;
    logic               accept;
    t_cmd               cmd;

    logic signed [31:0] d [MAX_POINTS];
    logic signed [31:0] c [MAX_POINTS];

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign cmd    = t_cmd'(i_command);

    genvar j;
    generate
        for (j = 0; j < MAX_POINTS; j++) begin : g_cell
            logic signed [31:0] d_next, c_next;
            logic               sel;
            if (j == MAX_POINTS - 1) begin : g_end
                assign d_next = '0;
                assign c_next = c[0];
            end else begin : g_mid
                assign d_next = d[j+1];
                assign c_next = c[j+1];
            end
            assign sel = ctl.load_en ? (r_count == CNT_W'(j)) : (r_i == CNT_W'(j));
            nfi_cell u_cell (
                .i_clk    (i_clk),
                .i_ctl    (ctl),
                .i_sel    (sel),
                .i_d_next (d_next),
                .i_c_next (c_next),
                .o_d      (d[j]),
                .o_c      (c[j])
            );
        end
    endgenerate

    nfi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && cmd == CMD_COMPUTE && r_count >= CNT_W'(2) && r_step != 0) begin
                    n_state = S_C_EMIT0;
                end else if (accept && cmd == CMD_EVAL && r_ready && r_step != 0) begin
                    n_state = S_E_DIVGO;
                end
            end
            S_C_EMIT0:   n_state = S_C_START;
            S_C_START:   n_state = S_C_MULK;
            S_C_MULK:    n_state = S_C_DIVGO;
            S_C_DIVGO:   n_state = S_C_DIVW;
            S_C_DIVW: begin
                if (div_done) begin
                    n_state = (r_k == r_i) ? S_C_EMIT : S_C_MULK;
                end
            end
            S_C_EMIT: begin
                n_state = (CNT_W'(r_i + 1'b1) == r_count) ? S_IDLE : S_C_START;
            end
            S_E_DIVGO:   n_state = S_E_DIVW;
            S_E_DIVW:    n_state = div_done ? S_E_MUL1 : S_E_DIVW;
            S_E_MUL1:    n_state = S_E_RND1;
            S_E_RND1:    n_state = S_E_ACC;
            S_E_ACC:     n_state = S_E_MUL2;
            S_E_MUL2:    n_state = S_E_RND2;
            S_E_RND2: begin
                n_state = (CNT_W'(r_i + 1'b1) == r_count) ? S_E_RESTORE : S_E_MUL1;
            end
            S_E_RESTORE: n_state = (r_rot == CNT_W'(MAX_POINTS)) ? S_IDLE : S_E_RESTORE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctl       = '0;
        ctl.y_data = i_y_value;
        ctl.c_data = r_acc;
        div_start = 1'b0;
        n_strobe  = 1'b0;
        n_result  = '0;
        n_index   = '0;
        n_status  = ST_OK;
        n_last    = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_LOAD: begin
                            n_strobe = 1'b1;
                            if (r_count >= CNT_W'(MAX_POINTS)) begin
                                n_status = ST_FULL;
                            end else begin
                                ctl.load_en = 1'b1;
                            end
                        end
                        CMD_COMPUTE: begin
                            if (r_count < CNT_W'(2)) begin
                                n_strobe = 1'b1;
                                n_status = ST_FEW;
                            end else if (r_step == 0) begin
                                n_strobe = 1'b1;
                                n_status = ST_ZERO_STEP;
                            end else begin
                                ctl.copy_en = 1'b1;
                            end
                        end
                        CMD_EVAL: begin
                            if (!r_ready || r_step == 0) begin
                                n_strobe = 1'b1;
                                n_status = ST_NOT_READY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_C_EMIT0: begin
                ctl.c_data  = d[0];
                ctl.cwr_en  = 1'b1;
                ctl.diff_en = 1'b1;
                n_strobe    = 1'b1;
                n_result    = d[0];
                n_last      = 1'b0;
            end
            S_C_DIVGO, S_E_DIVGO: div_start = 1'b1;
            S_C_EMIT: begin
                ctl.cwr_en  = 1'b1;
                ctl.diff_en = 1'b1;
                n_strobe    = 1'b1;
                n_result    = r_acc;
                n_index     = 4'(r_i);
                n_last      = (CNT_W'(r_i + 1'b1) == r_count);
            end
            S_E_DIVW:    ctl.rot_en = div_done;
            S_E_RND2:    ctl.rot_en = 1'b1;
            S_E_RESTORE: begin
                if (r_rot == CNT_W'(MAX_POINTS)) begin
                    n_strobe = 1'b1;
                    n_result = r_res;
                end else begin
                    ctl.rot_en = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ready  <= 1'b0;
            r_origin <= '0;
            r_step   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (r_state == S_IDLE && accept && cmd == CMD_LOAD
                    && r_count < CNT_W'(MAX_POINTS)) begin
                if (r_count == '0) begin
                    r_origin <= i_x_value;
                end else if (r_count == CNT_W'(1)) begin
                    r_step <= sat34(34'(i_x_value) - 34'(r_origin));
                end
                r_count <= r_count + 1'b1;
                r_ready <= 1'b0;
            end
            if (r_state == S_C_EMIT && CNT_W'(r_i + 1'b1) == r_count) begin
                r_ready <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_index  <= n_index;
        r_status <= n_status;
        r_last   <= n_last;
        case (r_state)
            S_IDLE: begin
                r_i   <= '0;
                r_num <= NUM_W'({34'(i_x_value) - 34'(r_origin), 16'h0});
                r_den <= DEN_W'(r_step);
            end
            S_C_EMIT0: r_i <= CNT_W'(1);
            S_C_START: begin
                r_acc <= d[0];
                r_k   <= CNT_W'(1);
            end
            S_C_MULK: begin
                r_den <= DEN_W'($signed({1'b0, r_k}) * r_step);
                r_num <= NUM_W'($signed({r_acc, 16'h0}));
            end
            S_C_DIVW: begin
                if (div_done) begin
                    r_acc <= div_quot;
                    r_k   <= r_k + 1'b1;
                end
            end
            S_C_EMIT:  r_i <= r_i + 1'b1;
            S_E_DIVW: begin
                if (div_done) begin
                    r_q    <= div_quot;
                    r_prod <= div_quot;
                    r_res  <= c[0];
                    r_rot  <= CNT_W'(1);
                    r_i    <= CNT_W'(1);
                end
            end
            S_E_MUL1:  r_p <= r_prod * c[0];
            S_E_RND1:  r_t <= mul_round(r_p);
            S_E_ACC: begin
                r_res <= sat34(34'(r_res) + 34'(r_t));
                r_qm  <= sat34(34'(r_q) - $signed(34'(r_i) << 16));
            end
            S_E_MUL2:  r_p <= r_prod * r_qm;
            S_E_RND2: begin
                r_prod <= mul_round(r_p);
                r_rot  <= r_rot + 1'b1;
                r_i    <= r_i + 1'b1;
            end
            S_E_RESTORE: begin
                if (r_rot != CNT_W'(MAX_POINTS)) begin
                    r_rot <= r_rot + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_strobe       = r_strobe;
    assign o_result_value = r_result;
    assign o_coef_index   = r_index;
    assign o_status       = r_status;
    assign o_last         = r_last;

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status != ST_OK |-> o_result_value == 0)
        else $error("nonzero status with nonzero value");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_C_DIVW || r_state == S_E_DIVW)
        else $error("divider finished outside a wait state");

    a_ignore_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && cmd == CMD_NONE |=> !o_strobe && !busy)
        else $error("ignored command produced activity");

    a_busy_no_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> $stable(r_count))
        else $error("point count changed while busy");

endmodule
